// ----- hw/rtl/bmut_pkg.sv -----
`default_nettype none

package bmut_pkg;

    // Class numbers travel between controller and datapath on a fixed width
    // that covers the largest supported class count.
    localparam int CLS_W = 4;

    typedef logic [CLS_W-1:0] t_cls;

    typedef struct packed {
        logic       ld;        // write the accepted load item into the store
        logic       q_start;   // latch the accepted query and clear the label
        logic       issue;     // issue one store read for class n, corner j
        t_cls       n;
        logic [1:0] j;
        logic       out_load;  // move the finished label into the output register
    } t_cmd;

    typedef struct packed {
        logic skip;            // query outside the frame, or no classes in use
        t_cls last_n;          // last class in use
        logic busy;            // interpolation pipeline still holds reads
        logic out_block;       // output register holds an item not taken this cycle
    } t_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/bmut_ram.sv -----
`default_nettype none

module bmut_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bmut_ctrl.sv -----
`default_nettype none

module bmut_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_operation,
    output logic               o_in_ready,
    input  wire bmut_pkg::t_sts i_sts,
    output bmut_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAP1  = 3'd1;
    localparam logic [2:0] ST_MAP2  = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;

    logic [2:0]          r_state, n_state;
    bmut_pkg::t_cls      r_n, n_n;
    logic [1:0]          r_j, n_j;
    logic                accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state        = r_state;
        n_n            = r_n;
        n_j            = r_j;
        o_cmd          = '0;
        o_cmd.ld       = accept && !i_operation;
        o_cmd.n        = r_n;
        o_cmd.j        = r_j;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_operation) begin
                    o_cmd.q_start = 1'b1;
                    n_state       = ST_MAP1;
                end
            end
            ST_MAP1: begin
                n_state = ST_MAP2;
            end
            ST_MAP2: begin
                n_n     = '0;
                n_j     = '0;
                n_state = i_sts.skip ? ST_DRAIN : ST_RUN;
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                n_j         = r_j + 2'd1;
                if (r_j == 2'd3) begin
                    n_n = r_n + 1'b1;
                    if (r_n == i_sts.last_n) begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy && !i_sts.out_block) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_n     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_j     <= n_j;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bmut_dp.sv -----
`default_nettype none

module bmut_dp #(
    parameter int MAX_CLASSES = 4,
    parameter int SRC_ROWS    = 256,
    parameter int SRC_COLS    = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire bmut_pkg::t_cmd     i_cmd,
    output bmut_pkg::t_sts          o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [24:0]        i_cfg_data,
    input  wire logic [1:0]         i_class_index,
    input  wire logic [7:0]         i_src_row,
    input  wire logic [7:0]         i_src_col,
    input  wire logic signed [15:0] i_logit_value,
    input  wire logic [10:0]        i_dst_row,
    input  wire logic [10:0]        i_dst_col,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [2:0]              o_label,
    output logic [10:0]             o_out_row,
    output logic [10:0]             o_out_col
);

    localparam int CAW   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int RAW   = $clog2(SRC_ROWS);
    localparam int XAW   = $clog2(SRC_COLS);
    localparam int AW    = CAW + RAW + XAW;
    localparam int DEPTH = 1 << AW;

    localparam logic [2:0] REG_SRC_W = 3'd0;
    localparam logic [2:0] REG_SRC_H = 3'd1;
    localparam logic [2:0] REG_DST_W = 3'd2;
    localparam logic [2:0] REG_DST_H = 3'd3;
    localparam logic [2:0] REG_X_STP = 3'd4;
    localparam logic [2:0] REG_Y_STP = 3'd5;
    localparam logic [2:0] REG_THR   = 3'd6;
    localparam logic [2:0] REG_CC    = 3'd7;

    typedef struct packed {
        logic [19:0] s0;
        logic [19:0] s1;
        logic [11:0] a;
    } t_axis;

    // Half-pixel-centre mapping with an 11-bit rounded fraction and clamping.
    function automatic t_axis map_axis(input logic [36:0] prod, input logic [20:0] size);
        t_axis       r;
        logic [36:0] t;
        logic [17:0] fr;
        r  = '0;
        t  = prod - 37'd65536;
        fr = {1'b0, t[16:0]} + 18'd32;
        if (prod >= 37'd65536) begin
            r.s0 = t[36:17];
            r.a  = fr[17:6];
        end
        if (r.s0 >= 20'(size - 21'd1)) begin
            r.s0 = 20'(size - 21'd1);
            r.a  = '0;
        end
        r.s1 = (r.s0 == 20'(size - 21'd1)) ? r.s0 : r.s0 + 20'd1;
        return r;
    endfunction

    // Configuration registers.
    logic [8:0]         r_src_w, r_src_h;
    logic [11:0]        r_dst_w, r_dst_h;
    logic [24:0]        r_x_step, r_y_step;
    logic [15:0]        r_thr;
    logic [2:0]         r_cc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= 9'd256;
            r_src_h  <= 9'd256;
            r_dst_w  <= 12'd256;
            r_dst_h  <= 12'd256;
            r_x_step <= 25'd65536;
            r_y_step <= 25'd65536;
            r_thr    <= '0;
            r_cc     <= 3'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SRC_W: r_src_w  <= i_cfg_data[8:0];
                REG_SRC_H: r_src_h  <= i_cfg_data[8:0];
                REG_DST_W: r_dst_w  <= i_cfg_data[11:0];
                REG_DST_H: r_dst_h  <= i_cfg_data[11:0];
                REG_X_STP: r_x_step <= i_cfg_data;
                REG_Y_STP: r_y_step <= i_cfg_data;
                REG_THR:   r_thr    <= i_cfg_data[15:0];
                REG_CC:    r_cc     <= i_cfg_data[2:0];
                default:   ;
            endcase
        end
    end

    // Effective class count and source sizes.
    logic [4:0]  cc_eff;
    logic [20:0] size_x, size_y;

    always_comb begin
        cc_eff = {2'b00, r_cc};
        if (cc_eff > 5'(MAX_CLASSES)) begin
            cc_eff = 5'(MAX_CLASSES);
        end
        size_x = 21'(r_src_w);
        if (size_x == 21'd0) size_x = 21'd1;
        if (size_x > 21'(SRC_COLS)) size_x = 21'(SRC_COLS);
        size_y = 21'(r_src_h);
        if (size_y == 21'd0) size_y = 21'd1;
        if (size_y > 21'(SRC_ROWS)) size_y = 21'(SRC_ROWS);
    end

    // Query capture and coordinate mapping.
    logic [10:0] r_drow, r_dcol;
    logic        r_skip;
    logic [36:0] r_xprod, r_yprod;
    t_axis       r_xa, r_ya;

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_drow <= i_dst_row;
            r_dcol <= i_dst_col;
            r_skip <= !((12'(i_dst_row) < r_dst_h) && (12'(i_dst_col) < r_dst_w))
                      || (r_cc == 3'd0);
        end
        r_xprod <= 37'({r_dcol, 1'b1}) * 37'(r_x_step);
        r_yprod <= 37'({r_drow, 1'b1}) * 37'(r_y_step);
        r_xa    <= map_axis(r_xprod, size_x);
        r_ya    <= map_axis(r_yprod, size_y);
    end

    // Logit store.
    logic [31:0]       ld_cls, ld_row, ld_col, rd_cls;
    logic              ld_ok;
    logic [AW-1:0]     waddr, raddr;
    logic [19:0]       rd_y, rd_x;
    logic signed [15:0] rdata;

    always_comb begin
        ld_cls = 32'(i_class_index);
        ld_row = 32'(i_src_row);
        ld_col = 32'(i_src_col);
        rd_cls = 32'(i_cmd.n);
        ld_ok  = (ld_cls < 32'(MAX_CLASSES)) && (ld_row < 32'(SRC_ROWS))
                 && (ld_col < 32'(SRC_COLS));
        waddr  = {ld_cls[CAW-1:0], ld_row[RAW-1:0], ld_col[XAW-1:0]};
        rd_y   = i_cmd.j[1] ? r_ya.s1 : r_ya.s0;
        rd_x   = i_cmd.j[0] ? r_xa.s1 : r_xa.s0;
        raddr  = {rd_cls[CAW-1:0], rd_y[RAW-1:0], rd_x[XAW-1:0]};
    end

    bmut_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld && ld_ok),
        .i_waddr (waddr),
        .i_wdata (i_logit_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Interpolation pipeline: horizontal weight, row sum, vertical weight,
    // column sum and threshold compare.
    logic                s1_v, s2_v, s3_v, s4_v;
    logic [1:0]          s1_j, s2_j;
    logic                s3_bot, s4_bot;
    bmut_pkg::t_cls      s1_n, s2_n, s3_n, s4_n;
    logic signed [28:0]  r_prod;
    logic signed [28:0]  r_hpart;
    logic signed [29:0]  r_htot;
    logic signed [42:0]  r_vprod;
    logic signed [42:0]  r_vpart;
    logic [2:0]          r_label;
    logic signed [12:0]  wx, wy;
    logic signed [43:0]  vsum, thr_ext;

    always_comb begin
        wx      = s1_j[0] ? $signed({1'b0, r_xa.a}) : $signed({1'b0, 12'd2048 - r_xa.a});
        wy      = s3_bot  ? $signed({1'b0, r_ya.a}) : $signed({1'b0, 12'd2048 - r_ya.a});
        vsum    = 44'(r_vpart) + 44'(r_vprod);
        thr_ext = {{6{r_thr[15]}}, r_thr, 22'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            s1_v <= 1'b0;
            s2_v <= 1'b0;
            s3_v <= 1'b0;
            s4_v <= 1'b0;
        end else begin
            s1_v <= i_cmd.issue;
            s2_v <= s1_v;
            s3_v <= s2_v && s2_j[0];
            s4_v <= s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        s1_j   <= i_cmd.j;
        s1_n   <= i_cmd.n;
        s2_j   <= s1_j;
        s2_n   <= s1_n;
        s3_bot <= s2_j[1];
        s3_n   <= s2_n;
        s4_bot <= s3_bot;
        s4_n   <= s3_n;
        r_prod <= wx * rdata;
        if (s2_v) begin
            if (!s2_j[0]) begin
                r_hpart <= r_prod;
            end else begin
                r_htot <= 30'(r_hpart) + 30'(r_prod);
            end
        end
        r_vprod <= wy * r_htot;
        if (i_cmd.q_start) begin
            r_label <= '0;
        end else if (s4_v) begin
            if (!s4_bot) begin
                r_vpart <= r_vprod;
            end else if (vsum > thr_ext) begin
                r_label <= 3'(s4_n + 1'b1);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_label   <= r_skip ? 3'd0 : r_label;
            o_out_row <= r_drow;
            o_out_col <= r_dcol;
        end
    end

    always_comb begin
        o_sts.skip      = r_skip;
        o_sts.last_n    = bmut_pkg::t_cls'(cc_eff - 5'd1);
        o_sts.busy      = s1_v || s2_v || s3_v || s4_v;
        o_sts.out_block = o_out_valid && !i_out_ready;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bilinear_mask_upscale_threshold.sv -----
// A load item is written into the store at the accepting edge.
// A query item goes from acceptance through the mapping states MAP1 and MAP2, four
// store reads per class, a four-stage drain and the output load, which waits for a
// free output register. Out-of-frame queries skip the reads; a query blocks all input.
// Reset clears the control state and configuration; the logit store holds
// undefined contents until written, with no clearing pass.
`default_nettype none

module bilinear_mask_upscale_threshold #(
    parameter int MAX_CLASSES = 4,
    parameter int SRC_ROWS    = 256,
    parameter int SRC_COLS    = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel.
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_operation,
    input  wire logic [1:0]         i_class_index,
    input  wire logic [7:0]         i_src_row,
    input  wire logic [7:0]         i_src_col,
    input  wire logic signed [15:0] i_logit_value,
    input  wire logic [10:0]        i_dst_row,
    input  wire logic [10:0]        i_dst_col,
    // Result channel.
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [2:0]              o_label,
    output logic [10:0]             o_out_row,
    output logic [10:0]             o_out_col,
    // Configuration write port.
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [24:0]        i_cfg_data
);

    // The controller sequences each query: it steps through the mapping
    // states, walks the four corners of every class in use, then waits for
    // the pipeline to empty and the output register to be free.
    bmut_pkg::t_cmd cmd;
    bmut_pkg::t_sts sts;

    bmut_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // The datapath holds the configuration, the store, the bilinear
    // arithmetic and the output register.
    bmut_dp #(
        .MAX_CLASSES (MAX_CLASSES),
        .SRC_ROWS    (SRC_ROWS),
        .SRC_COLS    (SRC_COLS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_class_index (i_class_index),
        .i_src_row     (i_src_row),
        .i_src_col     (i_src_col),
        .i_logit_value (i_logit_value),
        .i_dst_row     (i_dst_row),
        .i_dst_col     (i_dst_col),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_label       (o_label),
        .o_out_row     (o_out_row),
        .o_out_col     (o_out_col)
    );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes of the input channel.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes of the configuration port, in register order.
    typedef enum logic [2:0] {
        REG_SRC_WIDTH   = 3'd0,
        REG_SRC_HEIGHT  = 3'd1,
        REG_DST_WIDTH   = 3'd2,
        REG_DST_HEIGHT  = 3'd3,
        REG_X_STEP      = 3'd4,
        REG_Y_STEP      = 3'd5,
        REG_THRESHOLD   = 3'd6,
        REG_CLASS_COUNT = 3'd7
    } t_reg;

    localparam int ITEM_TARGET  = 1950;
    localparam int STALL_LIMIT  = 5000;  // cycles with no item moving on either side
    localparam int SETTLE       = 40;    // longest query latency with some margin
    localparam int HOLD_CYCLES  = 300;   // receiver hold-off used to fill the block

    typedef struct {
        logic [2:0]  label;
        logic [10:0] row;
        logic [10:0] col;
    } t_label_item;

    // The scoreboard keeps its own copy of the logit store and registers, works
    // out the label of every accepted query and checks results in order.
    class label_scoreboard;
        logic [15:0]  logits [int];
        logic [8:0]   src_w = 9'd256, src_h = 9'd256;
        logic [11:0]  dst_w = 12'd256, dst_h = 12'd256;
        logic [24:0]  step_x = 25'd65536, step_y = 25'd65536;
        logic [15:0]  thr = 16'd0;
        logic [2:0]   classes = 3'd1;
        t_label_item  pending [$];
        int           errors = 0;

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            errors++;
        endtask

        function void set_reg(t_reg idx, logic [24:0] value);
            case (idx)
                REG_SRC_WIDTH:   src_w   = value[8:0];
                REG_SRC_HEIGHT:  src_h   = value[8:0];
                REG_DST_WIDTH:   dst_w   = value[11:0];
                REG_DST_HEIGHT:  dst_h   = value[11:0];
                REG_X_STEP:      step_x  = value;
                REG_Y_STEP:      step_y  = value;
                REG_THRESHOLD:   thr     = value[15:0];
                REG_CLASS_COUNT: classes = value[2:0];
                default: ;
            endcase
        endfunction

        // One axis of the half-pixel-centre mapping with edge clamping.
        function void map_axis(longint d, longint step, longint size,
                               output longint s0, output longint s1, output longint a);
            longint prod;
            longint t;
            prod = (2 * d + 1) * step;
            s0 = 0;
            a  = 0;
            if (prod >= 65536) begin
                t  = prod - 65536;
                s0 = t >>> 17;
                a  = ((t & 'h1FFFF) + 32) >>> 6;
            end
            if (s0 >= size - 1) begin
                s0 = size - 1;
                a  = 0;
            end
            s1 = (s0 + 1 < size) ? s0 + 1 : size - 1;
        endfunction

        function int used_classes();
            return (classes > 3'd4) ? 4 : int'(classes);
        endfunction

        function bit in_frame(logic [10:0] r, logic [10:0] c);
            return (r < dst_h) && (c < dst_w) && (used_classes() > 0);
        endfunction

        // Store addresses of the four neighbours of one pixel, for every class.
        function void corner_addrs(logic [10:0] r, logic [10:0] c, ref int addrs[$]);
            longint sw, sh, x0, x1, y0, y1, ax, ay;
            addrs.delete();
            if (!in_frame(r, c))
                return;
            sw = (src_w == 0) ? 1 : (src_w > 256) ? 256 : src_w;
            sh = (src_h == 0) ? 1 : (src_h > 256) ? 256 : src_h;
            map_axis(c, step_x, sw, x0, x1, ax);
            map_axis(r, step_y, sh, y0, y1, ay);
            for (int n = 0; n < used_classes(); n++) begin
                addrs = {addrs, n * 65536 + int'(y0) * 256 + int'(x0)};
                addrs = {addrs, n * 65536 + int'(y0) * 256 + int'(x1)};
                addrs = {addrs, n * 65536 + int'(y1) * 256 + int'(x0)};
                addrs = {addrs, n * 65536 + int'(y1) * 256 + int'(x1)};
            end
        endfunction

        function longint logit_at(int addr);
            return logits.exists(addr) ? longint'($signed(logits[addr])) : 0;
        endfunction

        function logic [2:0] label_of(logic [10:0] r, logic [10:0] c);
            longint top, bot, v, limit, sw, sh, x0, x1, y0, y1, ax, ay;
            logic [2:0] lbl;
            lbl = 3'd0;
            if (!in_frame(r, c))
                return lbl;
            sw = (src_w == 0) ? 1 : (src_w > 256) ? 256 : src_w;
            sh = (src_h == 0) ? 1 : (src_h > 256) ? 256 : src_h;
            map_axis(c, step_x, sw, x0, x1, ax);
            map_axis(r, step_y, sh, y0, y1, ay);
            limit = longint'($signed(thr)) * (longint'(1) << 22);
            for (int n = 0; n < used_classes(); n++) begin
                top = (2048 - ax) * logit_at(n * 65536 + int'(y0 * 256 + x0))
                    + ax * logit_at(n * 65536 + int'(y0 * 256 + x1));
                bot = (2048 - ax) * logit_at(n * 65536 + int'(y1 * 256 + x0))
                    + ax * logit_at(n * 65536 + int'(y1 * 256 + x1));
                v = (2048 - ay) * top + ay * bot;
                if (v > limit)
                    lbl = 3'(n + 1);
            end
            return lbl;
        endfunction

        // Called for every accepted input item.
        function void note_item(logic op, logic [1:0] cls, logic [7:0] sr, logic [7:0] sc,
                                logic [15:0] value, logic [10:0] dr, logic [10:0] dc);
            t_label_item e;
            if (op == OP_LOAD) begin
                logits[int'(cls) * 65536 + int'(sr) * 256 + int'(sc)] = value;
            end else begin
                e.label = label_of(dr, dc);
                e.row   = dr;
                e.col   = dc;
                pending = {pending, e};
            end
        endfunction

        task check_label(logic [2:0] lbl, logic [10:0] r, logic [10:0] c);
            t_label_item e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected label %0d for (%0d,%0d)", lbl, r, c));
                return;
            end
            e = pending.pop_front();
            if (lbl !== e.label)
                report($sformatf("label %0d, expected %0d at (%0d,%0d)", lbl, e.label,
                                 e.row, e.col));
            if (r !== e.row)
                report($sformatf("out_row %0d, expected %0d", r, e.row));
            if (c !== e.col)
                report($sformatf("out_col %0d, expected %0d", c, e.col));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_operation = OP_LOAD;
    logic [1:0]         i_class_index = '0;
    logic [7:0]         i_src_row = '0;
    logic [7:0]         i_src_col = '0;
    logic signed [15:0] i_logit_value = '0;
    logic [10:0]        i_dst_row = '0;
    logic [10:0]        i_dst_col = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_label;
    logic [10:0]        o_out_row;
    logic [10:0]        o_out_col;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [24:0]        i_cfg_data = '0;

    bilinear_mask_upscale_threshold dut (.*);

    always #5 i_clk = ~i_clk;

    label_scoreboard sb = new();

    // Store entries that the stimulus has already loaded. A query is only sent
    // once every neighbour it will read holds a loaded value.
    bit  loaded [int];
    int  items_sent = 0;
    int  send_idle = 35;   // percentage of cycles in which the sender holds back
    int  recv_idle = 83;   // percentage of cycles in which the receiver holds back
    logic hold_req = 1'b0;
    bit   hold_done = 1'b0;

    // The idling pattern follows progress through the run: sender light and
    // receiver heavy, then the reverse, then a stretch at full rate.
    function void pick_idling();
        if (items_sent < ITEM_TARGET / 3) begin
            send_idle = 35;
            recv_idle = 83;
        end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            send_idle = 83;
            recv_idle = 35;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endfunction

    task automatic send_item(logic op, logic [1:0] cls, logic [7:0] sr, logic [7:0] sc,
                             logic [15:0] value, logic [10:0] dr, logic [10:0] dc);
        pick_idling();
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_class_index <= cls;
        i_src_row     <= sr;
        i_src_col     <= sc;
        i_logit_value <= value;
        i_dst_row     <= dr;
        i_dst_col     <= dc;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_item(op, cls, sr, sc, value, dr, dc);
        items_sent++;
    endtask

    task automatic load_logit(int addr, logic [15:0] value);
        loaded[addr] = 1'b1;
        send_item(OP_LOAD, 2'(addr >> 16), 8'(addr >> 8), 8'(addr), value,
                  11'($urandom), 11'($urandom));
    endtask

    // Loads every neighbour the query will read that has not been loaded yet,
    // with random content, and then sends the query itself.
    task automatic query_pixel(logic [10:0] dr, logic [10:0] dc);
        int addrs[$];
        sb.corner_addrs(dr, dc, addrs);
        foreach (addrs[k])
            if (!loaded.exists(addrs[k]))
                load_logit(addrs[k], 16'($urandom));
        send_item(OP_QUERY, 2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                  dr, dc);
    endtask

    // Registers may only change with the block idle: every label in, then a
    // pause long enough for the block to finish whatever it still holds.
    task automatic write_config(logic [8:0] sw, logic [8:0] sh, logic [11:0] dw,
                                logic [11:0] dh, logic [24:0] xs, logic [24:0] ys,
                                logic [15:0] th, logic [2:0] cc);
        logic [24:0] values[8];
        values = '{25'(sw), 25'(sh), 25'(dw), 25'(dh), xs, ys, 25'(th), 25'(cc)};
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        for (int k = 0; k < 8; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(k);
            i_cfg_data  <= values[k];
            @(posedge i_clk);
            sb.set_reg(t_reg'(k), values[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Picks a pixel near the frame, now and then anywhere in the full range so
    // that every coordinate bit toggles and out-of-frame queries occur.
    task automatic random_query();
        logic [10:0] dr, dc;
        if ($urandom_range(9) == 0) begin
            dr = 11'($urandom);
            dc = 11'($urandom);
        end else begin
            dr = 11'($urandom_range(0, int'(sb.dst_h) + int'(sb.dst_h) / 8));
            dc = 11'($urandom_range(0, int'(sb.dst_w) + int'(sb.dst_w) / 8));
        end
        query_pixel(dr, dc);
    endtask

    task automatic random_phase();
        int          sw, sh, dw, dh, n;
        logic [24:0] xs, ys;
        logic [15:0] th;
        sw = ($urandom_range(7) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 12);
        sh = ($urandom_range(7) == 0) ? $urandom_range(1, 256) : $urandom_range(1, 12);
        dw = ($urandom_range(7) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 48);
        dh = ($urandom_range(7) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 48);
        // Steps follow the size ratio as the host would set them, with jitter.
        xs = 25'(((longint'(sw) << 16) / dw) + $urandom_range(0, 64) - 32);
        ys = 25'(((longint'(sh) << 16) / dh) + $urandom_range(0, 64) - 32);
        if (xs == 0) xs = 25'd1;
        if (ys == 0) ys = 25'd1;
        th = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
        write_config(9'(sw), 9'(sh), 12'(dw), 12'(dh), xs, ys, th,
                     3'($urandom_range(1, 4)));
        n = $urandom_range(40, 120);
        repeat (n) begin
            if (items_sent >= ITEM_TARGET)
                break;
            if ($urandom_range(4) == 0)
                load_logit($urandom_range(0, 262143), 16'($urandom));
            else
                random_query();
            // One long hold-off on the receiver once the run is at full rate,
            // so the block fills and holds off further input.
            if (!hold_done && recv_idle == 0) begin
                hold_done = 1'b1;
                hold_req <= 1'b1;
            end
        end
    endtask

    // Result side: checks every accepted label and drives ready.
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_label(o_label, o_out_row, o_out_col);
        if (hold_req) begin
            hold_req  <= 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog: the run is stuck if neither side moves an item for too long.
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: extreme logits at two opposite corners of the map,
        // a query at the two matching frame corners and two just outside the frame.
        load_logit(0, 16'h8000);
        load_logit(3 * 65536 + 255 * 256 + 255, 16'h7FFF);
        query_pixel(11'd0, 11'd0);
        query_pixel(11'd255, 11'd255);
        query_pixel(11'd256, 11'd0);
        query_pixel(11'd2047, 11'd2047);

        // Single-pixel source, largest frame, smallest step, lowest threshold.
        write_config(9'd1, 9'd1, 12'd2048, 12'd2048, 25'd1, 25'd1, 16'h8000, 3'd4);
        query_pixel(11'd0, 11'd2047);
        query_pixel(11'd2047, 11'd0);
        query_pixel(11'd1024, 11'd1023);

        // Full-size source, one-pixel frame, a step of 256 source pixels, highest threshold.
        write_config(9'd256, 9'd256, 12'd1, 12'd1, 25'd16777216, 25'd16777216,
                     16'h7FFF, 3'd4);
        query_pixel(11'd0, 11'd0);
        query_pixel(11'd0, 11'd1);

        // Out-of-range sizes and class count: width 0 acts as one column, a
        // height above the map acts as its full height, seven classes as four.
        write_config(9'd0, 9'd511, 12'd16, 12'd16, 25'd0, 25'd1048576, 16'd0, 3'd7);
        query_pixel(11'd3, 11'd5);
        query_pixel(11'd15, 11'd15);

        // No classes in use: every label is background.
        write_config(9'd4, 9'd4, 12'd8, 12'd8, 25'd32768, 25'd32768, 16'd0, 3'd0);
        query_pixel(11'd2, 11'd2);

        // Plain upscale by four with a zero threshold.
        write_config(9'd8, 9'd5, 12'd32, 12'd20, 25'd16384, 25'd16384, 16'd0, 3'd3);
        query_pixel(11'd0, 11'd31);
        query_pixel(11'd19, 11'd0);
        query_pixel(11'd10, 11'd13);

        while (items_sent < ITEM_TARGET)
            random_phase();

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d labels never arrived", sb.pending.size()));
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
